@@ rtl/source_text_tokenizer_macros.svh @@
// Assertion macros for the source text tokenizer.
// Included by RTL files that carry concurrent checks; depends on nothing.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Property must hold on every edge outside reset.
`define STT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define STT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/stt_pkg.sv @@
// Token codes, character classes and keyword table for the tokenizer.
// No dependencies.
package stt_pkg;

   localparam logic [5:0] KIND_IDENT    = 6'd0;
   localparam logic [5:0] KIND_NUM      = 6'd1;
   localparam logic [5:0] KIND_STRING   = 6'd2;
   localparam logic [5:0] KIND_DECLARE  = 6'd3;
   localparam logic [5:0] KIND_SLASH    = 6'd8;
   localparam logic [5:0] KIND_TERNARY  = 6'd25;
   localparam logic [5:0] KIND_GTE      = 6'd28;
   localparam logic [5:0] KIND_LTE      = 6'd29;
   localparam logic [5:0] KIND_EQ       = 6'd30;
   localparam logic [5:0] KIND_NEQ      = 6'd31;
   localparam logic [5:0] KIND_AND      = 6'd32;
   localparam logic [5:0] KIND_OR       = 6'd33;
   localparam logic [5:0] KIND_FUNCTION = 6'd34;
   localparam logic [5:0] KIND_ILLEGAL  = 6'd43;
   localparam logic [5:0] KIND_END      = 6'd44;

   localparam int KW_COUNT = 10;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] line;
      logic [15:0] start;
      logic [15:0] length;
      logic        err;
      logic        last;
   } token_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
   endfunction

   function automatic logic may_pair(input logic [7:0] c);
      return c == "=" || c == "-" || c == "!" || c == "|" || c == "&" ||
             c == ">" || c == "<" || c == "/";
   endfunction

   // Single-character kind; flag low for unknown symbols.
   function automatic logic [6:0] single_kind(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      case (c)
         "=": r = {1'b1, 6'd4};   "+": r = {1'b1, 6'd5};   "-": r = {1'b1, 6'd6};
         "*": r = {1'b1, 6'd7};   "/": r = {1'b1, 6'd8};   "%": r = {1'b1, 6'd9};
         "(": r = {1'b1, 6'd10};  ")": r = {1'b1, 6'd11};  "{": r = {1'b1, 6'd12};
         "}": r = {1'b1, 6'd13};  "[": r = {1'b1, 6'd14};  "]": r = {1'b1, 6'd15};
         ";": r = {1'b1, 6'd16};  ":": r = {1'b1, 6'd17};  ",": r = {1'b1, 6'd18};
         "!": r = {1'b1, 6'd19};  "|": r = {1'b1, 6'd20};  "&": r = {1'b1, 6'd21};
         "^": r = {1'b1, 6'd22};  ".": r = {1'b1, 6'd23};  "$": r = {1'b1, 6'd24};
         ">": r = {1'b1, 6'd26};  "<": r = {1'b1, 6'd27};
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   // Two-character operator kind; flag low if the pair is not an operator.
   function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
      logic [6:0] r;
      r = 7'd0;
      if (a == "=" && b == "=") r = {1'b1, KIND_EQ};
      if (a == "-" && b == ">") r = {1'b1, KIND_TERNARY};
      if (a == "!" && b == "=") r = {1'b1, KIND_NEQ};
      if (a == "|" && b == "|") r = {1'b1, KIND_OR};
      if (a == "&" && b == "&") r = {1'b1, KIND_AND};
      if (a == ">" && b == "=") r = {1'b1, KIND_GTE};
      if (a == "<" && b == "=") r = {1'b1, KIND_LTE};
      return r;
   endfunction

   localparam logic [KW_COUNT-1:0][63:0] KW_TEXT = '{
      64'(32'h_66_6e_63), 64'(16'h_69_66), 64'(32'h_65_6c_73_65),
      64'(40'h_77_68_69_6c_65), 64'(48'h_72_65_74_75_72_6e),
      64'(40'h_62_72_65_61_6b), 64'h_63_6f_6e_74_69_6e_75_65,
      64'(32'h_74_72_75_65), 64'(40'h_66_61_6c_73_65), 64'(32'h_64_65_63_6c)
   };
   localparam logic [KW_COUNT-1:0][5:0] KW_KIND = '{
      6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, KIND_DECLARE
   };

   function automatic logic [5:0] word_kind(input logic [63:0] w);
      logic [5:0] k;
      k = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++)
         if (w == KW_TEXT[i]) k = KW_KIND[i];
      return k;
   endfunction

endpackage

@@ rtl/source_text_tokenizer.sv @@
// Streaming source text tokenizer: one byte per transfer in, tokens out.
// Depends on stt_pkg and source_text_tokenizer_macros.svh.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_text_byte, req_end_of_text
//   rsp     | out       | rsp_valid, rsp_stall, rsp_token_kind .. rsp_last_token
//
// While req_stall is low, one byte is scanned per cycle: the scanner state updates in a
// single pass and up to two tokens drop into a four-entry output queue in the same cycle.
// req_stall rises while the queue has fewer than two free entries, so a stalled
// rsp side holds back the req side only once three or more tokens wait; with rsp free, a byte per cycle.
// reset (synchronous) clears the scanner to line 1, offset 0, and empties the queue.
`include "source_text_tokenizer_macros.svh"

module source_text_tokenizer import stt_pkg::*; #(
   parameter int OFFSET_BITS = 16,
   parameter int LINE_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_literal_length,
   output logic        rsp_error_flag,
   output logic        rsp_last_token
);

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_OPER, MODE_WORD, MODE_NUMBER, MODE_STRING, MODE_COMMENT
   } mode_type;

   localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam int OW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
   localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;

   // scanner state
   mode_type               mode_ff, mode_in;
   logic [7:0]             held_ff, held_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] bc_ff, bc_in;
   logic [OFFSET_BITS-1:0] tb_ff, tb_in;
   logic [63:0]            word_ff, word_in;
   logic                   long_ff, long_in;
   logic                   dot_ff, dot_in;
   logic                   bad_ff, bad_in;

   // output queue
   token_type  q_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   logic accept, pop;
   logic [7:0] c;
   logic ending, handled;
   logic [15:0] line16, bc16, tb16, len16;
   logic [OFFSET_BITS-1:0] len_raw;
   logic [OFFSET_BITS-1:0] bc_inc;
   logic [6:0] sk, pk, hk;
   logic pend_v;
   token_type pend, fresh, t0, t1, endtok;
   logic fresh_v, t0_v, t1_v;

   assign accept = req_valid && !req_stall;
   assign pop    = rsp_valid && !rsp_stall;
   assign c      = req_text_byte;
   assign ending = req_end_of_text || (c == 8'd0);

   // saturate counters into the 16-bit result fields
   always_comb begin
      logic [LW-1:0] le;
      logic [OW-1:0] be, te, ne;
      le = LW'(line_ff);
      be = OW'(bc_ff);
      te = OW'(tb_ff);
      len_raw = (tb_ff <= bc_ff) ? bc_ff - tb_ff : '0;
      ne = OW'(len_raw);
      line16 = (le > LW'(17'h0FFFF)) ? 16'hFFFF : le[15:0];
      bc16   = (be > OW'(17'h0FFFF)) ? 16'hFFFF : be[15:0];
      tb16   = (te > OW'(17'h0FFFF)) ? 16'hFFFF : te[15:0];
      len16  = (ne > OW'(17'h0FFFF)) ? 16'hFFFF : ne[15:0];
   end

   assign bc_inc = (bc_ff == OFS_MAX) ? bc_ff : bc_ff + 1'b1;
   assign sk = single_kind(c);
   assign pk = pair_kind(held_ff, c);
   assign hk = single_kind(held_ff);

   // token closed by whatever ends the pending run
   always_comb begin
      pend = '{kind: KIND_IDENT, line: line16, start: tb16, length: len16,
               err: 1'b0, last: 1'b0};
      pend_v = 1'b1;
      case (mode_ff)
         MODE_WORD:   pend.kind = long_ff ? KIND_IDENT : word_kind(word_ff);
         MODE_NUMBER: begin
            pend.kind = bad_ff ? KIND_ILLEGAL : KIND_NUM;
            pend.err  = bad_ff;
         end
         MODE_OPER: begin
            pend.kind   = hk[6] ? hk[5:0] : KIND_ILLEGAL;
            pend.err    = !hk[6];
            pend.length = 16'd1;
         end
         MODE_STRING: begin
            pend.kind = KIND_STRING;
            pend.err  = 1'b1;
         end
         default: pend_v = 1'b0;
      endcase
   end

   assign endtok = '{kind: KIND_END, line: line16, start: bc16, length: 16'd0,
                     err: 1'b0, last: 1'b1};

   always_comb begin
      mode_in = mode_ff;  held_in = held_ff;  line_in = line_ff;
      bc_in = bc_inc;     tb_in = tb_ff;      word_in = word_ff;
      long_in = long_ff;  dot_in = dot_ff;    bad_in = bad_ff;
      t0 = pend;  t0_v = 1'b0;  t1 = endtok;  t1_v = 1'b0;
      fresh = '{kind: sk[5:0], line: line16, start: bc16, length: 16'd1,
                err: 1'b0, last: 1'b0};
      fresh_v = 1'b0;
      handled = 1'b0;

      if (ending) begin
         // flush, emit end, then start a new text
         t0_v = pend_v;  t1_v = 1'b1;
         mode_in = MODE_IDLE;  held_in = '0;  line_in = LINE_BITS'(1);
         bc_in = '0;  tb_in = '0;  word_in = '0;
         long_in = 1'b0;  dot_in = 1'b0;  bad_in = 1'b0;
      end else begin
         case (mode_ff)
            MODE_STRING: begin
               handled = 1'b1;
               if (c == "\"") begin
                  t0 = pend;  t0.err = 1'b0;  t0_v = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_COMMENT: begin
               handled = 1'b1;
               if (c == 8'h0A) begin
                  line_in = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_WORD: if (is_letter(c)) begin
               handled = 1'b1;
               if (word_ff[63:56] != 8'd0) long_in = 1'b1;
               else word_in = {word_ff[55:0], c};
            end
            MODE_NUMBER: if (is_digit(c)) begin
               handled = 1'b1;
            end else if (c == ".") begin
               handled = 1'b1;
               dot_in = 1'b1;
               if (dot_ff) bad_in = 1'b1;
            end
            MODE_OPER: if (held_ff == "/" && c == "/") begin
               handled = 1'b1;
               mode_in = MODE_COMMENT;
            end else if (pk[6]) begin
               handled = 1'b1;
               t0 = '{kind: pk[5:0], line: line16, start: tb16, length: 16'd2,
                      err: 1'b0, last: 1'b0};
               t0_v = 1'b1;
               mode_in = MODE_IDLE;
            end
            default: ;
         endcase

         if (!handled) begin
            t0_v = pend_v;
            mode_in = MODE_IDLE;
            if (is_blank(c)) begin
               if (c == 8'h0A)
                  line_in = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
            end else if (is_letter(c)) begin
               mode_in = MODE_WORD;  tb_in = bc_ff;
               word_in = 64'(c);  long_in = 1'b0;
            end else if (is_digit(c)) begin
               mode_in = MODE_NUMBER;  tb_in = bc_ff;
               dot_in = 1'b0;  bad_in = 1'b0;
            end else if (c == "\"") begin
               mode_in = MODE_STRING;  tb_in = bc_inc;
            end else if (may_pair(c)) begin
               mode_in = MODE_OPER;  held_in = c;  tb_in = bc_ff;
            end else begin
               fresh_v = 1'b1;
               if (!sk[6]) begin
                  fresh.kind = KIND_ILLEGAL;  fresh.err = 1'b1;  fresh.length = 16'd0;
               end
            end
            t1 = fresh;  t1_v = fresh_v;
         end
      end
   end

   // pack two candidate tokens into queue writes
   logic [1:0] push_n;
   token_type  w0, w1;
   always_comb begin
      push_n = 2'(t0_v) + 2'(t1_v);
      w0 = t0_v ? t0 : t1;
      w1 = t1;
   end

   assign req_stall = cnt_ff > 3'd2;
   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_token_kind     = q_ff[rd_ff].kind;
   assign rsp_line_number    = q_ff[rd_ff].line;
   assign rsp_start_offset   = q_ff[rd_ff].start;
   assign rsp_literal_length = q_ff[rd_ff].length;
   assign rsp_error_flag     = q_ff[rd_ff].err;
   assign rsp_last_token     = q_ff[rd_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;  held_ff <= '0;  line_ff <= LINE_BITS'(1);
         bc_ff <= '0;  tb_ff <= '0;  word_ff <= '0;
         long_ff <= 1'b0;  dot_ff <= 1'b0;  bad_ff <= 1'b0;
         wr_ff <= '0;  rd_ff <= '0;  cnt_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;  held_ff <= held_in;  line_ff <= line_in;
            bc_ff <= bc_in;  tb_ff <= tb_in;  word_ff <= word_in;
            long_ff <= long_in;  dot_ff <= dot_in;  bad_ff <= bad_in;
            wr_ff <= wr_ff + push_n;
         end
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (accept ? 3'(push_n) : 3'd0) - (pop ? 3'd1 : 3'd0);
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (accept && push_n != 2'd0) q_ff[wr_ff] <= w0;
      if (accept && push_n == 2'd2) q_ff[wr_ff + 2'd1] <= w1;
   end

   `STT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= 3'd4, "token queue overflow")
   `STT_ALWAYS(a_line_nonzero, clock, reset, line_ff != '0, "line counter reached zero")
   `STT_IMPLIES(a_begin_order, clock, reset,
      mode_ff == MODE_WORD || mode_ff == MODE_NUMBER || mode_ff == MODE_STRING,
      tb_ff <= bc_ff, "token start beyond byte count")

endmodule

@@ bench/tb.sv @@
// Self-checking bench for source_text_tokenizer: drives bytes and end marks, predicts tokens.
// Depends on stt_pkg and the source_text_tokenizer RTL only.
`timescale 1ns / 100ps

module tb import stt_pkg::*; ();

   typedef enum logic [5:0] {
      T_IDENT, T_NUM, T_STRING, T_DECLARE, T_ASSIGN, T_PLUS, T_MINUS, T_ASTERISK, T_SLASH,
      T_PERCENT, T_LPAREN, T_RPAREN, T_LBRACE, T_RBRACE, T_LBRACKET, T_RBRACKET,
      T_SEMICOLON, T_COLON, T_COMMA, T_BANG, T_BAR, T_AMPERSAND, T_CIRCUMFLEX, T_DOT,
      T_DOLLAR, T_TERNARY, T_GT, T_LT, T_GTE, T_LTE, T_EQ, T_NEQ, T_AND, T_OR,
      T_FUNCTION, T_IF, T_ELSE, T_WHILE, T_RETURN, T_BREAK, T_CONTINUE, T_TRUE, T_FALSE,
      T_ILLEGAL, T_END
   } kind_type;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_OPER, SCAN_WORD, SCAN_NUMBER, SCAN_STRING, SCAN_COMMENT
   } scan_type;

   localparam int SAT16 = 65535;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   // Token predictor plus queue of expected tokens.
   class token_scoreboard;
      token_type   expected_tokens[$];
      int          mismatches;
      scan_type    mode;
      logic [7:0]  held;
      int          line_no, byte_pos, tok_begin;
      logic [63:0] prefix;
      bit          too_long, dot_seen, num_bad;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         mode = SCAN_IDLE; held = 8'd0; line_no = 1; byte_pos = 0; tok_begin = 0;
         prefix = 64'd0; too_long = 0; dot_seen = 0; num_bad = 0;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      function int bump(int v);
         return (v >= SAT16) ? SAT16 : v + 1;
      endfunction

      function void push_token(kind_type k, int start, int len, bit err, bit last);
         token_type t;
         t.kind = k; t.line = 16'(line_no); t.start = 16'(start);
         t.length = 16'(len); t.err = err; t.last = last;
         expected_tokens.push_back(t);
      endfunction

      function bit letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit pairable(logic [7:0] c);
         return c == "=" || c == "-" || c == "!" || c == "|" || c == "&" ||
                c == ">" || c == "<" || c == "/";
      endfunction

      function kind_type lone_kind(logic [7:0] c);
         case (c)
            "=": return T_ASSIGN;    "+": return T_PLUS;      "-": return T_MINUS;
            "*": return T_ASTERISK;  "/": return T_SLASH;     "%": return T_PERCENT;
            "(": return T_LPAREN;    ")": return T_RPAREN;    "{": return T_LBRACE;
            "}": return T_RBRACE;    "[": return T_LBRACKET;  "]": return T_RBRACKET;
            ";": return T_SEMICOLON; ":": return T_COLON;     ",": return T_COMMA;
            "!": return T_BANG;      "|": return T_BAR;       "&": return T_AMPERSAND;
            "^": return T_CIRCUMFLEX; ".": return T_DOT;      "$": return T_DOLLAR;
            ">": return T_GT;        "<": return T_LT;
            default: return T_ILLEGAL;
         endcase
      endfunction

      // T_ILLEGAL here means the two bytes do not form an operator.
      function kind_type duo_kind(logic [7:0] a, logic [7:0] b);
         if (a == "=" && b == "=") return T_EQ;
         if (a == "-" && b == ">") return T_TERNARY;
         if (a == "!" && b == "=") return T_NEQ;
         if (a == "|" && b == "|") return T_OR;
         if (a == "&" && b == "&") return T_AND;
         if (a == ">" && b == "=") return T_GTE;
         if (a == "<" && b == "=") return T_LTE;
         return T_ILLEGAL;
      endfunction

      function kind_type keyword_kind();
         if (too_long) return T_IDENT;
         case (prefix)
            64'("fnc"):      return T_FUNCTION;
            64'("if"):       return T_IF;
            64'("else"):     return T_ELSE;
            64'("while"):    return T_WHILE;
            64'("return"):   return T_RETURN;
            64'("break"):    return T_BREAK;
            64'("continue"): return T_CONTINUE;
            64'("true"):     return T_TRUE;
            64'("false"):    return T_FALSE;
            64'("decl"):     return T_DECLARE;
            default:         return T_IDENT;
         endcase
      endfunction

      function int string_len();
         return (tok_begin <= byte_pos) ? byte_pos - tok_begin : 0;
      endfunction

      function void flush_token();
         kind_type k;
         case (mode)
            SCAN_WORD:   push_token(keyword_kind(), tok_begin, byte_pos - tok_begin, 0, 0);
            SCAN_NUMBER: push_token(num_bad ? T_ILLEGAL : T_NUM, tok_begin,
                                    byte_pos - tok_begin, num_bad, 0);
            SCAN_OPER: begin
               k = lone_kind(held);
               push_token(k, tok_begin, 1, k == T_ILLEGAL, 0);
            end
            SCAN_STRING: push_token(T_STRING, tok_begin, string_len(), 1, 0);
            default: ;
         endcase
         mode = SCAN_IDLE;
      endfunction

      function void start_token(logic [7:0] c);
         kind_type k;
         if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
            if (c == 8'h0A) line_no = bump(line_no);
         end else if (letter(c)) begin
            mode = SCAN_WORD; tok_begin = byte_pos; prefix = 64'(c); too_long = 0;
         end else if (digit(c)) begin
            mode = SCAN_NUMBER; tok_begin = byte_pos; dot_seen = 0; num_bad = 0;
         end else if (c == "\"") begin
            mode = SCAN_STRING; tok_begin = bump(byte_pos);
         end else if (pairable(c)) begin
            mode = SCAN_OPER; held = c; tok_begin = byte_pos;
         end else begin
            k = lone_kind(c);
            if (k == T_ILLEGAL) push_token(T_ILLEGAL, byte_pos, 0, 1, 0);
            else push_token(k, byte_pos, 1, 0, 0);
         end
      endfunction

      // Note one accepted input transfer.
      function void note_byte(logic [7:0] c, logic eot);
         bit consumed;
         kind_type k;
         consumed = 0;
         if (eot || c == 8'd0) begin
            flush_token();
            push_token(T_END, byte_pos, 0, 0, 1);
            clear();
            return;
         end
         case (mode)
            SCAN_STRING: begin
               if (c == "\"") begin
                  push_token(T_STRING, tok_begin, string_len(), 0, 0);
                  mode = SCAN_IDLE;
               end
               consumed = 1;
            end
            SCAN_COMMENT: begin
               if (c == 8'h0A) begin
                  line_no = bump(line_no);
                  mode = SCAN_IDLE;
               end
               consumed = 1;
            end
            SCAN_WORD: if (letter(c)) begin
               if (prefix[63:56] != 8'd0) too_long = 1;
               else prefix = {prefix[55:0], c};
               consumed = 1;
            end
            SCAN_NUMBER: if (digit(c)) begin
               consumed = 1;
            end else if (c == ".") begin
               if (dot_seen) num_bad = 1;
               dot_seen = 1;
               consumed = 1;
            end
            SCAN_OPER: if (held == "/" && c == "/") begin
               mode = SCAN_COMMENT;
               consumed = 1;
            end else begin
               k = duo_kind(held, c);
               if (k != T_ILLEGAL) begin
                  push_token(k, tok_begin, 2, 0, 0);
                  mode = SCAN_IDLE;
                  consumed = 1;
               end
            end
            default: ;
         endcase
         if (!consumed) begin
            flush_token();
            start_token(c);
         end
         byte_pos = bump(byte_pos);
      endfunction

      // Compare one accepted token with the oldest expectation.
      function void check_token(token_type got);
         token_type want;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token kind %0d line %0d start %0d", $time,
                     got.kind, got.line, got.start);
            mismatches++;
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            mismatches++;
         end
         if (got.line !== want.line) begin
            $display("%0t: line expected %0d actual %0d", $time, want.line, got.line);
            mismatches++;
         end
         if (got.start !== want.start) begin
            $display("%0t: start expected %0d actual %0d", $time, want.start, got.start);
            mismatches++;
         end
         if (got.length !== want.length) begin
            $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
            mismatches++;
         end
         if (got.err !== want.err) begin
            $display("%0t: error expected %0b actual %0b", $time, want.err, got.err);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_text_byte;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_token_kind;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_literal_length;
   logic        rsp_error_flag;
   logic        rsp_last_token;

   token_scoreboard tokens_sb = new();

   bit quiet;        // no idling on either side
   bit hold_rsp;     // ask the receiver for one long hold-off
   int sent_items;
   int idle_cycles = 0;

   source_text_tokenizer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_line_number    (rsp_line_number),
      .rsp_start_offset   (rsp_start_offset),
      .rsp_literal_length (rsp_literal_length),
      .rsp_error_flag     (rsp_error_flag),
      .rsp_last_token     (rsp_last_token)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Both channels are sampled at the edge, before the NBA updates land:
   // byte transfers feed the predictor, token transfers get checked.
   always @(posedge clock) begin
      token_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            tokens_sb.note_byte(req_text_byte, req_end_of_text);
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_token_kind; got.line = rsp_line_number;
            got.start = rsp_start_offset; got.length = rsp_literal_length;
            got.err = rsp_error_flag; got.last = rsp_last_token;
            tokens_sb.check_token(got);
         end
         // watchdog: cycles with no transfer on either side
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("source_text_tokenizer regression: fail");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, none when quiet.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 0;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            n = $urandom_range(1, 14);
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (n) @(posedge clock);
         end
      end
   end

   // One input transfer; called at a rising edge, returns at the accepting edge.
   task automatic send_item(logic [7:0] b, logic eot);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // End mark: sometimes the flag, sometimes a zero byte, with random payload bits.
   task automatic send_end();
      if ($urandom_range(0, 1)) send_item(8'($urandom_range(0, 255)), 1'b1);
      else send_item(8'd0, 1'b0);
   endtask

   task automatic wait_drained();
      while (tokens_sb.pending() != 0) @(posedge clock);
   endtask

   // Random, mostly well-formed fragments with some raw noise bytes.
   task automatic send_fragment();
      string words[$] = '{"fnc", "if", "else", "while", "return", "break", "continue",
                          "true", "false", "decl", "x", "Abc", "continuex", "whiles",
                          "abcdefghijk", "Zz"};
      string ops[$] = '{"==", "->", "!=", "||", "&&", ">=", "<=", "=", "-", "!", "|",
                        "&", ">", "<", "/", "+", "*", "%", "(", ")", "{", "}", "[", "]",
                        ";", ":", ",", "^", ".", "$", "=+", "<>"};
      string blanks[$] = '{" ", "\t", "\r", "\n", "  "};
      string s;
      case ($urandom_range(0, 9))
         0, 1: send_text(words[$urandom_range(0, words.size() - 1)]);
         2: begin
            s = "";
            repeat ($urandom_range(1, 5)) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
            if ($urandom_range(0, 1)) s = {s, "."};
            if ($urandom_range(0, 2) == 0) s = {s, "7."};
            send_text(s);
         end
         3, 4: send_text(ops[$urandom_range(0, ops.size() - 1)]);
         5: send_text($urandom_range(0, 1) ? "\"ab c\"" : "\"x\ny\"");
         6: send_text("// note x\n");
         7: send_item(8'($urandom_range(1, 255)), 1'b0);
         8: if ($urandom_range(0, 5) == 0) send_end();
            else send_text(words[$urandom_range(0, words.size() - 1)]);
         default: ;
      endcase
      send_text(blanks[$urandom_range(0, blanks.size() - 1)]);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = 8'd0;
      req_end_of_text = 1'b0;
      quiet           = 0;
      hold_rsp        = 0;
      sent_items      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: keywords, long word, numbers, bad number, lone dot, pairs
      send_text("fnc decl continue abcdefghij 1.5 1.2.3 .x");
      send_end();
      send_text("== -> != || && >= <= =+ #");
      send_item(8'h80, 1'b0);
      send_item(8'hFF, 1'b0);
      send_end();
      // string with LF, comment to LF, then pending operator, unterminated string
      send_text("\"a\nb\" // c\n< \"open");
      send_item(8'h7F, 1'b1);
      send_text("// tail");
      send_end();
      send_text("ab&");
      send_end();

      // long receiver hold-off while the sender keeps pushing
      hold_rsp = 1;
      send_text("a b c d e f g h ; ; ; ; ( ) ( ) 1 2 3");
      send_end();
      // sender pause until every token is back
      req_valid <= 1'b0;
      wait_drained();

      while (sent_items < 165) begin
         if (sent_items > 150) quiet = 1;
         send_fragment();
      end
      quiet = 1;
      send_end();
      req_valid <= 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (tokens_sb.mismatches == 0 && tokens_sb.pending() == 0)
         $display("source_text_tokenizer regression: pass");
      else
         $display("source_text_tokenizer regression: fail");
      $finish;
   end

endmodule
